// File: rtl/static_linked_list_engine_defines.svh
// Assertion macros used by the static linked list engine top level.
`ifndef STATIC_LINKED_LIST_ENGINE_DEFINES_SVH
`define STATIC_LINKED_LIST_ENGINE_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define SLL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define SLL_ASSERT_NEVER(lbl, cond, msg) `SLL_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/sll_pkg.sv
// Package: types, constants and helpers of the static linked list engine.
`default_nettype none

package sll_pkg;

    localparam int SLOTS      = 256;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int CAPACITY   = SLOTS - 2;

    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [VALUE_BITS-1:0] val_t;

    localparam slot_t HEAD_SLOT = slot_t'(SLOTS - 1);
    localparam slot_t FREE_SLOT = slot_t'(0);

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_LOCATE = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         position;
        logic signed [31:0] value;
    } item_t;

    typedef struct packed {
        logic               status;
        logic signed [31:0] removed_value;
        logic [7:0]         found_slot;
        logic [7:0]         list_length;
    } result_t;

    // Link store access: one read and one write per cycle.
    typedef struct packed {
        logic  rd_en;
        slot_t rd_addr;
        logic  wr_en;
        slot_t wr_addr;
        slot_t wr_data;
    } lk_req_t;

    // Power-up link: a chain through the free slots, ending at 0.
    function automatic slot_t link_reset(slot_t idx);
        slot_t r;
        r = (int'(idx) < SLOTS - 2) ? slot_t'(int'(idx) + 1) : slot_t'(0);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sll_link_store.sv
// Link store: slot link memory with registered read and per-slot valid bits.
`default_nettype none

module sll_link_store
    import sll_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire lk_req_t req,
    output slot_t        rd_data
);

    slot_t          mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    logic           rd_valid_reg;
    slot_t          rd_data_reg;
    slot_t          rd_addr_reg;

    // Valid bits stand in for the reset chain until a slot is written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
                valid_reg[req.wr_addr] <= 1'b1;
            if (req.rd_en)
                rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
            rd_addr_reg <= req.rd_addr;
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : link_reset(rd_addr_reg);

endmodule

`default_nettype wire

// File: rtl/static_linked_list_engine.sv
// Top level: sequencer of the static linked list engine.
//
// Usage:
//   Command channel: item is taken at a rising edge with start high and busy
//   low. Kinds are append, insert before position, delete at position and
//   locate value.
//   Result channel: done is high for one cycle with result valid; the
//   receiver takes it at that edge and cannot hold it off.
// Sequencing:
//   A rejected command (full, bad position, empty locate) returns its result
//   in the cycle after acceptance, and busy stays low.
//   Append/insert: walk to the node before the target position, then read
//   the free head, pop it, link the new slot and link its predecessor.
//   Delete: walk, unlink the node, return its slot. Locate: scan node by node.
//   Walks run one link store read per cycle through its registered read port.
// Throughput: one command at a time; busy is high until its result shows.
// Reset: the list is empty and all free slots are chained; no clearing pass
//   is needed, the link store's valid bits supply the power-up chain.
`default_nettype none
`include "static_linked_list_engine_defines.svh"

module static_linked_list_engine
    import sll_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire item_t item,
    output logic       busy,
    output logic       done,
    output result_t    result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_A_FREE,
        S_A_NEXT,
        S_A_LINK_NEW,
        S_A_LINK_PREV,
        S_D_NEXT,
        S_D_FREE,
        S_D_RETURN,
        S_LOC_FIRST,
        S_SCAN
    } state_t;

    state_t  state_reg, state_next;
    kind_t   kind_reg, kind_next;
    val_t    val_reg, val_next;
    slot_t   k_reg, k_next;
    slot_t   s_reg, s_next;
    slot_t   nk_reg, nk_next;
    slot_t   j_reg, j_next;
    slot_t   target_reg, target_next;
    slot_t   count_reg, count_next;
    logic    done_reg, done_next;
    result_t result_reg, result_next;

    lk_req_t lk_req;
    slot_t   lk_q;
    logic    ok;

    logic    vs_wr_en;
    logic    vs_rd_en;
    val_t    vs_q;
    val_t    vs_mem [SLOTS];

    function automatic result_t make_result(logic st, val_t rem, slot_t found, slot_t cnt);
        result_t r;
        r.status        = st;
        r.removed_value = 32'(rem);
        r.found_slot    = 8'(found);
        r.list_length   = 8'(cnt);
        return r;
    endfunction

    sll_link_store u_link_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (lk_req),
        .rd_data (lk_q)
    );

    // Value store: written at the allocated slot, read at the slot just fetched.
    always_ff @(posedge clk)
    begin
        if (vs_wr_en)
            vs_mem[s_reg] <= val_reg;
        if (vs_rd_en)
            vs_q <= vs_mem[lk_q];
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        val_next    = val_reg;
        k_next      = k_reg;
        s_next      = s_reg;
        nk_next     = nk_reg;
        j_next      = j_reg;
        target_next = target_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        lk_req      = '0;
        vs_wr_en    = 1'b0;
        vs_rd_en    = 1'b0;
        ok          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next = item.kind;
                    val_next  = val_t'(item.value);
                    k_next    = HEAD_SLOT;
                    j_next    = '0;
                    case (item.kind)
                        KIND_APPEND:
                        begin
                            ok          = int'(count_reg) < CAPACITY;
                            target_next = count_reg;
                        end
                        KIND_INSERT:
                        begin
                            ok          = (int'(count_reg) < CAPACITY)
                                       && (int'(item.position) < int'(count_reg));
                            target_next = slot_t'(item.position);
                        end
                        KIND_DELETE:
                        begin
                            ok          = int'(item.position) < int'(count_reg);
                            target_next = slot_t'(item.position);
                        end
                        default:
                        begin
                            ok          = count_reg != '0;
                            target_next = '0;
                        end
                    endcase
                    if (ok)
                    begin
                        lk_req.rd_en   = 1'b1;
                        lk_req.rd_addr = HEAD_SLOT;
                        state_next     = (item.kind == KIND_LOCATE) ? S_LOC_FIRST : S_WALK;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        result_next = make_result(1'b1, '0, '0, count_reg);
                    end
                end
            end

            // lk_q holds the link of k_reg; j_reg links followed so far
            S_WALK:
            begin
                if (j_reg == target_reg)
                begin
                    nk_next = lk_q;
                    if (kind_reg == KIND_APPEND || kind_reg == KIND_INSERT)
                    begin
                        lk_req.rd_en   = 1'b1;
                        lk_req.rd_addr = FREE_SLOT;
                        state_next     = S_A_FREE;
                    end
                    else if (lk_q == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = make_result(1'b1, '0, '0, count_reg);
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        s_next         = lk_q;
                        lk_req.rd_en   = 1'b1;
                        lk_req.rd_addr = lk_q;
                        vs_rd_en       = 1'b1;
                        state_next     = S_D_NEXT;
                    end
                end
                else
                begin
                    k_next         = lk_q;
                    j_next         = j_reg + slot_t'(1);
                    lk_req.rd_en   = 1'b1;
                    lk_req.rd_addr = lk_q;
                end
            end

            S_A_FREE:
            begin
                if (lk_q == '0)
                begin
                    done_next   = 1'b1;
                    result_next = make_result(1'b1, '0, '0, count_reg);
                    state_next  = S_IDLE;
                end
                else
                begin
                    s_next         = lk_q;
                    lk_req.rd_en   = 1'b1;
                    lk_req.rd_addr = lk_q;
                    state_next     = S_A_NEXT;
                end
            end

            // pop: free head takes the new slot's old link
            S_A_NEXT:
            begin
                lk_req.wr_en   = 1'b1;
                lk_req.wr_addr = FREE_SLOT;
                lk_req.wr_data = lk_q;
                vs_wr_en       = 1'b1;
                state_next     = S_A_LINK_NEW;
            end

            S_A_LINK_NEW:
            begin
                lk_req.wr_en   = 1'b1;
                lk_req.wr_addr = s_reg;
                lk_req.wr_data = nk_reg;
                state_next     = S_A_LINK_PREV;
            end

            S_A_LINK_PREV:
            begin
                lk_req.wr_en   = 1'b1;
                lk_req.wr_addr = k_reg;
                lk_req.wr_data = s_reg;
                count_next     = count_reg + slot_t'(1);
                done_next      = 1'b1;
                result_next    = make_result(1'b0, '0, '0, count_reg + slot_t'(1));
                state_next     = S_IDLE;
            end

            // unlink the node; k_reg is never the free head
            S_D_NEXT:
            begin
                lk_req.wr_en   = 1'b1;
                lk_req.wr_addr = k_reg;
                lk_req.wr_data = lk_q;
                lk_req.rd_en   = 1'b1;
                lk_req.rd_addr = FREE_SLOT;
                state_next     = S_D_FREE;
            end

            S_D_FREE:
            begin
                lk_req.wr_en   = 1'b1;
                lk_req.wr_addr = s_reg;
                lk_req.wr_data = lk_q;
                state_next     = S_D_RETURN;
            end

            S_D_RETURN:
            begin
                lk_req.wr_en   = 1'b1;
                lk_req.wr_addr = FREE_SLOT;
                lk_req.wr_data = s_reg;
                count_next     = count_reg - slot_t'(1);
                done_next      = 1'b1;
                result_next    = make_result(1'b0, vs_q, '0, count_reg - slot_t'(1));
                state_next     = S_IDLE;
            end

            S_LOC_FIRST:
            begin
                if (lk_q == '0)
                begin
                    done_next   = 1'b1;
                    result_next = make_result(1'b1, '0, '0, count_reg);
                    state_next  = S_IDLE;
                end
                else
                begin
                    s_next         = lk_q;
                    j_next         = '0;
                    lk_req.rd_en   = 1'b1;
                    lk_req.rd_addr = lk_q;
                    vs_rd_en       = 1'b1;
                    state_next     = S_SCAN;
                end
            end

            // vs_q and lk_q belong to node number j_reg at slot s_reg
            S_SCAN:
            begin
                if (vs_q == val_reg)
                begin
                    done_next   = 1'b1;
                    result_next = make_result(1'b0, '0, s_reg, count_reg);
                    state_next  = S_IDLE;
                end
                else if ((int'(j_reg) + 1 >= int'(count_reg)) || (lk_q == '0))
                begin
                    done_next   = 1'b1;
                    result_next = make_result(1'b1, '0, '0, count_reg);
                    state_next  = S_IDLE;
                end
                else
                begin
                    s_next         = lk_q;
                    j_next         = j_reg + slot_t'(1);
                    lk_req.rd_en   = 1'b1;
                    lk_req.rd_addr = lk_q;
                    vs_rd_en       = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            kind_reg   <= KIND_APPEND;
            val_reg    <= '0;
            k_reg      <= '0;
            s_reg      <= '0;
            nk_reg     <= '0;
            j_reg      <= '0;
            target_reg <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            val_reg    <= val_next;
            k_reg      <= k_next;
            s_reg      <= s_next;
            nk_reg     <= nk_next;
            j_reg      <= j_next;
            target_reg <= target_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `SLL_ASSERT(a_done_has_cause, done |-> ($past(busy) || $past(start)), "result without a command")
    `SLL_ASSERT(a_busy_ends_with_result, $fell(busy) |-> done, "busy dropped without a result")
    `SLL_ASSERT_NEVER(a_count_bound, int'(count_reg) > CAPACITY, "element count over capacity")
    `SLL_ASSERT(a_found_is_ok, (done && result.found_slot != 8'd0) |-> !result.status,
                "found slot reported with error status")
    `SLL_ASSERT_NEVER(a_write_head_free, lk_req.wr_en && vs_wr_en && s_reg == FREE_SLOT,
                      "value written into the free list head")

endmodule

`default_nettype wire
